// File: src/padded_matrix_vector_transform_unit_macros.svh
// assertion helpers for the asserting module
`ifndef PADDED_MATRIX_VECTOR_TRANSFORM_UNIT_MACROS_SVH
`define PADDED_MATRIX_VECTOR_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define PMVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmvt assertion failed");

// next-cycle implication, off while reset is low
`define PMVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmvt assertion failed");

`endif

// File: src/pmvt_pkg.sv
package pmvt_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    // 8 truncated products of 48 bits plus one padding term
    localparam int ACC_W      = 52;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int OUT_IDX_W  = 3;

    localparam logic [CFG_DATA_W-1:0] IN_DIM_RST  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] OUT_DIM_RST = 4'd4;

    localparam logic FUNC_COEF = 1'b0;
    localparam logic FUNC_VEC  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_DIM,
        CFG_OUT_DIM,
        CFG_TRANSPOSE,
        CFG_BYPASS
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_PAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_prod;
        logic acc_pad;
    } t_mac_ctrl;

endpackage

// File: src/pmvt_ram.sv
module pmvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pmvt_mac.sv
module pmvt_mac (
    input  logic                                  i_clk,
    input  pmvt_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [pmvt_pkg::DATA_W-1:0]    i_vec,
    input  logic signed [pmvt_pkg::DATA_W-1:0]    i_coef,
    output logic signed [pmvt_pkg::DATA_W-1:0]    o_result,
    output logic                                  o_sat
);

    localparam int AccW  = pmvt_pkg::ACC_W;
    localparam int ProdW = pmvt_pkg::PROD_W;
    localparam int DataW = pmvt_pkg::DATA_W;
    localparam int FracW = pmvt_pkg::FRAC_W;

    logic signed [ProdW-1:0]       r_prod;
    logic signed [AccW-1:0]        r_acc;
    logic signed [AccW-1:0]        n_acc;
    logic signed [ProdW-FracW-1:0] prod_q;
    logic                          all_ones;
    logic                          all_zeros;

    // dropping the low bits of the two's complement product rounds toward minus infinity
    assign prod_q = r_prod[ProdW-1:FracW];

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_prod) begin
            n_acc = r_acc + AccW'(prod_q);
        end else if (i_ctrl.acc_pad) begin
            n_acc = r_acc + AccW'(i_vec);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctrl.mul_en) begin
            r_prod <= i_vec * i_coef;
        end
    end

    // in range when every bit above the sign position agrees
    assign all_ones  = &r_acc[AccW-1:DataW-1];
    assign all_zeros = ~|r_acc[AccW-1:DataW-1];
    assign o_sat     = !(all_ones || all_zeros);

    always_comb begin
        if (!o_sat) begin
            o_result = r_acc[DataW-1:0];
        end else if (r_acc[AccW-1]) begin
            o_result = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(DataW-1){1'b1}}};
        end
    end

endmodule

// File: src/padded_matrix_vector_transform_unit.sv
// Matrix-vector transform in signed Q16.16 around one shared multiply-accumulate unit.
// Coefficient writes and vector components other than the last are taken while idle.
// The last component starts the transform, during which the input is not ready: every
// output component repeats, for min(inner dimension, n) products, the coefficient
// memory read, the 32x32 multiply and the accumulate, then the padding add and the
// saturating load into the output register, which waits while the held result is not
// yet taken; in bypass mode each component takes only the padding add and the load. The
// single multiplier and the single read port of the coefficient memory serialize the
// products. The final result may still wait in the output register while the next beat
// is taken. Configuration writes are always ready and must only be issued while the block is idle.
`include "padded_matrix_vector_transform_unit_macros.svh"

module padded_matrix_vector_transform_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [pmvt_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pmvt_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    // input beats
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic                                     i_func,
    input  logic [2:0]                               i_row_index,
    input  logic [2:0]                               i_col_index,
    input  logic signed [pmvt_pkg::DATA_W-1:0]       i_data_value,
    input  logic                                     i_is_last,
    // result beats
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [pmvt_pkg::DATA_W-1:0]       o_component,
    output logic [pmvt_pkg::OUT_IDX_W-1:0]           o_component_index,
    output logic                                     o_last_component,
    output logic                                     o_saturated,
    output logic                                     o_dropped
);

    localparam int Cap    = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int CntW   = $clog2(Cap + 1);
    localparam int VidxW  = $clog2(Cap);
    localparam int Depth  = MAX_DIM * MAX_DIM;
    localparam int AddrW  = $clog2(Depth);
    localparam int DataW  = pmvt_pkg::DATA_W;
    localparam int CdW    = pmvt_pkg::CFG_DATA_W;

    // configuration registers
    logic [CdW-1:0]         r_in_dim;
    logic [CdW-1:0]         r_out_dim;
    logic                   r_transpose;
    logic                   r_bypass;

    // sequencer state
    pmvt_pkg::t_state       r_state;
    pmvt_pkg::t_state       n_state;
    logic [CntW-1:0]        r_i;
    logic [CntW-1:0]        n_i;
    logic [CntW-1:0]        r_j;
    logic [CntW-1:0]        n_j;
    logic [CntW-1:0]        r_count;
    logic                   r_ovf;
    logic [DataW-1:0]       r_vec [Cap];

    // output register
    logic                   r_out_valid;
    logic signed [DataW-1:0] r_out_comp;
    logic [pmvt_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic                   r_out_last;
    logic                   r_out_sat;
    logic                   r_out_drop;

    logic                   in_accept;
    logic                   vec_beat;
    logic                   start;
    logic                   out_load;
    logic                   out_last;
    logic [CntW-1:0]        idim;
    logic [CntW-1:0]        odim;
    logic [CntW-1:0]        dim_inner;
    logic [CntW-1:0]        dim_outer;
    logic [CntW-1:0]        inner;
    logic                   pad_cond;
    logic [VidxW-1:0]       vidx;
    logic                   coef_we;
    logic [AddrW-1:0]       coef_waddr;
    logic [AddrW-1:0]       coef_raddr;
    logic [DataW-1:0]       coef_rdata;
    logic signed [DataW-1:0] mac_result;
    logic                   mac_sat;
    pmvt_pkg::t_mac_ctrl    mac_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == pmvt_pkg::S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign vec_beat    = in_accept && (i_func == pmvt_pkg::FUNC_VEC);
    assign start       = vec_beat && i_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dim    <= pmvt_pkg::IN_DIM_RST;
            r_out_dim   <= pmvt_pkg::OUT_DIM_RST;
            r_transpose <= 1'b0;
            r_bypass    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pmvt_pkg::t_cfg_reg'(i_cfg_index))
                pmvt_pkg::CFG_IN_DIM:    r_in_dim    <= i_cfg_data;
                pmvt_pkg::CFG_OUT_DIM:   r_out_dim   <= i_cfg_data;
                pmvt_pkg::CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                pmvt_pkg::CFG_BYPASS:    r_bypass    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // dimensions clamped into 1..Cap
    always_comb begin
        if (r_in_dim == '0) begin
            idim = CntW'(1);
        end else if (int'(r_in_dim) > Cap) begin
            idim = CntW'(Cap);
        end else begin
            idim = CntW'(r_in_dim);
        end
        if (r_out_dim == '0) begin
            odim = CntW'(1);
        end else if (int'(r_out_dim) > Cap) begin
            odim = CntW'(Cap);
        end else begin
            odim = CntW'(r_out_dim);
        end
    end

    assign dim_inner = r_transpose ? odim : idim;
    assign dim_outer = r_bypass ? r_count : (r_transpose ? idim : odim);
    assign inner     = (dim_inner < r_count) ? dim_inner : r_count;
    // components past the matrix's inner dimension also add their input component
    assign pad_cond  = (dim_inner < r_count) && (r_i >= dim_inner) && (r_i < r_count);
    assign out_last  = (CntW'(r_i + 1'b1) == dim_outer);

    assign coef_we    = in_accept && (i_func == pmvt_pkg::FUNC_COEF)
                        && (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign coef_waddr = AddrW'(AddrW'(i_row_index) * AddrW'(MAX_DIM) + AddrW'(i_col_index));
    assign coef_raddr = r_transpose
                        ? AddrW'(AddrW'(r_i) * AddrW'(MAX_DIM) + AddrW'(r_j))
                        : AddrW'(AddrW'(r_j) * AddrW'(MAX_DIM) + AddrW'(r_i));

    pmvt_ram #(
        .WIDTH (DataW),
        .DEPTH (Depth)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_data_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    pmvt_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_vec    (r_vec[vidx]),
        .i_coef   (coef_rdata),
        .o_result (mac_result),
        .o_sat    (mac_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmvt_pkg::S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        mac_ctrl = '0;
        vidx     = r_i[VidxW-1:0];
        out_load = 1'b0;
        unique case (r_state)
            pmvt_pkg::S_IDLE: begin
                mac_ctrl.clear = 1'b1;
                if (start) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = r_bypass ? pmvt_pkg::S_PAD : pmvt_pkg::S_READ;
                end
            end
            pmvt_pkg::S_READ: begin
                n_state = pmvt_pkg::S_MUL;
            end
            pmvt_pkg::S_MUL: begin
                vidx            = r_j[VidxW-1:0];
                mac_ctrl.mul_en = 1'b1;
                n_state         = pmvt_pkg::S_ACC;
            end
            pmvt_pkg::S_ACC: begin
                mac_ctrl.acc_prod = 1'b1;
                n_j               = CntW'(r_j + 1'b1);
                n_state = (n_j == inner) ? pmvt_pkg::S_PAD : pmvt_pkg::S_READ;
            end
            pmvt_pkg::S_PAD: begin
                mac_ctrl.acc_pad = r_bypass || pad_cond;
                n_state          = pmvt_pkg::S_OUT;
            end
            pmvt_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load       = 1'b1;
                    mac_ctrl.clear = 1'b1;
                    n_j            = '0;
                    if (out_last) begin
                        n_state = pmvt_pkg::S_IDLE;
                    end else begin
                        n_i     = CntW'(r_i + 1'b1);
                        n_state = r_bypass ? pmvt_pkg::S_PAD : pmvt_pkg::S_READ;
                    end
                end
            end
            default: n_state = pmvt_pkg::S_IDLE;
        endcase
    end

    // vector collection; count and drop flag clear once the last result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (out_load && out_last) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (vec_beat) begin
            if (int'(r_count) < Cap) begin
                r_count <= CntW'(r_count + 1'b1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vec_beat && (int'(r_count) < Cap)) begin
            r_vec[r_count[VidxW-1:0]] <= i_data_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_comp <= mac_result;
            r_out_idx  <= pmvt_pkg::OUT_IDX_W'(r_i);
            r_out_last <= out_last;
            r_out_sat  <= mac_sat;
            r_out_drop <= r_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_component       = r_out_comp;
    assign o_component_index = r_out_idx;
    assign o_last_component  = r_out_last;
    assign o_saturated       = r_out_sat;
    assign o_dropped         = r_out_drop;

    `PMVT_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, int'(r_count) <= Cap)
    `PMVT_ASSERT_NEXT(a_idle_until_last, i_clk, i_rst_n,
        (r_state == pmvt_pkg::S_IDLE) && !start, r_state == pmvt_pkg::S_IDLE)
    `PMVT_ASSERT_NOW(a_term_in_range, i_clk, i_rst_n,
        r_state == pmvt_pkg::S_READ, (r_j < inner) && !r_bypass)
    `PMVT_ASSERT_NEXT(a_vector_cleared, i_clk, i_rst_n,
        out_load && out_last, (r_count == '0) && !r_ovf)
    `PMVT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, !out_load)

endmodule
